>>> rtl/nlt_pkg.sv
// Shared types, constants and the control program of the normalised Legendre table.
// Holds the micro-instruction format, the sequencer program and the fixed-point helpers.
// Used by the top level; depends on nothing else.
`default_nettype none

package nlt_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEGREE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ORDER  = 2'd1;

    // Fixed-point constants.
    localparam logic signed [31:0] ONE_Q24     = 32'sd16777216;
    localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
    localparam logic signed [31:0] PI_Q28      = 32'sd843314857;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [33:0] TRIG_ONE    = 34'sd1073741824;
    localparam int                 CORDIC_STEPS = 28;
    localparam int                 CIT_W        = 5;

    // Program counter width of the sequencer.
    localparam int PC_W = 7;

    typedef enum logic [2:0] {
        OP_NOP, OP_MOV, OP_ADD, OP_SUB, OP_NEG, OP_MUL, OP_RND
    } op_t;

    typedef enum logic [3:0] {
        SRC_R0, SRC_R1, SRC_R2, SRC_R3, SRC_R4, SRC_R5,
        SRC_MV, SRC_MS, SRC_ONE, SRC_ZERO
    } src_t;

    typedef enum logic [2:0] {
        MB_S, MB_C, MB_KD, MB_KS, MB_KB, MB_KA, MB_KC
    } mb_t;

    typedef enum logic [2:0] {
        AD_CUR, AD_DIAG, AD_SUB, AD_PD, AD_I1, AD_I2
    } addr_t;

    typedef enum logic [1:0] {
        CNT_KEEP, CNT_CLR, CNT_INC
    } cnt_t;

    typedef enum logic [2:0] {
        C_NEXT, C_ALWAYS, C_CORDIC_BUSY, C_D_IS_ONE, C_J_LT_D, C_D_EQ_N, C_GEN_STOP
    } cond_t;

    // One control word of the program.
    typedef struct packed {
        op_t             op;
        src_t            dst;
        src_t            src_a;
        src_t            src_b;
        mb_t             mb;
        logic            rd;
        logic            wr;
        addr_t           addr;
        logic            emit;
        cnt_t            j_op;
        cnt_t            d_op;
        cond_t           cond;
        logic [PC_W-1:0] target;
        logic            done;
    } uword_t;

    localparam uword_t UW_NOP = '{
        op: OP_NOP, dst: SRC_R0, src_a: SRC_ZERO, src_b: SRC_ZERO, mb: MB_S,
        rd: 1'b0, wr: 1'b0, addr: AD_CUR, emit: 1'b0, j_op: CNT_KEEP,
        d_op: CNT_KEEP, cond: C_NEXT, target: '0, done: 1'b0
    };

    // Jump targets of the program.
    localparam logic [PC_W-1:0] PC_WAITC = 7'd0;
    localparam logic [PC_W-1:0] PC_E0    = 7'd2;
    localparam logic [PC_W-1:0] PC_DG1   = 7'd21;
    localparam logic [PC_W-1:0] PC_SUBD  = 7'd31;
    localparam logic [PC_W-1:0] PC_G0    = 7'd43;
    localparam logic [PC_W-1:0] PC_EP    = 7'd71;
    localparam logic [PC_W-1:0] PC_DONE  = 7'd72;

    function automatic uword_t u_mul(input src_t a, input mb_t mb);
        uword_t w;
        w = UW_NOP;
        w.op = OP_MUL;
        w.src_a = a;
        w.mb = mb;
        return w;
    endfunction

    function automatic uword_t u_rnd(input src_t dst);
        uword_t w;
        w = UW_NOP;
        w.op = OP_RND;
        w.dst = dst;
        return w;
    endfunction

    function automatic uword_t u_alu(input op_t op, input src_t dst, input src_t a,
                                     input src_t b);
        uword_t w;
        w = UW_NOP;
        w.op = op;
        w.dst = dst;
        w.src_a = a;
        w.src_b = b;
        return w;
    endfunction

    function automatic uword_t u_wr(input addr_t addr, input src_t a, input src_t b);
        uword_t w;
        w = UW_NOP;
        w.wr = 1'b1;
        w.addr = addr;
        w.src_a = a;
        w.src_b = b;
        return w;
    endfunction

    function automatic uword_t u_rd(input addr_t addr);
        uword_t w;
        w = UW_NOP;
        w.rd = 1'b1;
        w.addr = addr;
        return w;
    endfunction

    // The sequencer program. R0/R1 hold the previous diagonal value and slope,
    // or the entry one degree down in the general recursion.
    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        w = UW_NOP;
        case (pc)
            // Wait for sine and cosine; start at degree zero.
            7'd0: begin
                w.cond = C_CORDIC_BUSY;
                w.target = PC_WAITC;
                w.d_op = CNT_CLR;
                w.j_op = CNT_CLR;
            end
            7'd1: w = u_wr(AD_CUR, SRC_ONE, SRC_ZERO);
            // Emission loop over the orders of the current degree.
            7'd2: w = u_rd(AD_CUR);
            7'd3: begin
                w.emit = 1'b1;
                w.j_op = CNT_INC;
                w.cond = C_J_LT_D;
                w.target = PC_E0;
            end
            7'd4: begin
                w.d_op = CNT_INC;
                w.cond = C_D_EQ_N;
                w.target = PC_DONE;
            end
            // Fetch the previous diagonal entry.
            7'd5: w = u_rd(AD_PD);
            7'd6: w = u_alu(OP_MOV, SRC_R0, SRC_MV, SRC_ZERO);
            7'd7: w = u_alu(OP_MOV, SRC_R1, SRC_MS, SRC_ZERO);
            7'd8: begin
                w.cond = C_D_IS_ONE;
                w.target = PC_DG1;
            end
            // Diagonal entry, degree two and above.
            7'd9:  w = u_mul(SRC_R0, MB_C);
            7'd10: w = u_rnd(SRC_R2);
            7'd11: w = u_mul(SRC_R2, MB_KD);
            7'd12: w = u_rnd(SRC_R2);
            7'd13: w = u_mul(SRC_R1, MB_C);
            7'd14: w = u_rnd(SRC_R3);
            7'd15: w = u_mul(SRC_R0, MB_S);
            7'd16: w = u_rnd(SRC_R4);
            7'd17: w = u_alu(OP_SUB, SRC_R3, SRC_R3, SRC_R4);
            7'd18: w = u_mul(SRC_R3, MB_KD);
            7'd19: w = u_rnd(SRC_R3);
            7'd20: begin
                w = u_wr(AD_DIAG, SRC_R2, SRC_R3);
                w.cond = C_ALWAYS;
                w.target = PC_SUBD;
            end
            // Diagonal entry of degree one.
            7'd21: w = u_mul(SRC_R0, MB_C);
            7'd22: w = u_rnd(SRC_R2);
            7'd23: w = u_mul(SRC_R2, MB_KD);
            7'd24: w = u_rnd(SRC_R2);
            7'd25: w = u_mul(SRC_R0, MB_S);
            7'd26: w = u_rnd(SRC_R3);
            7'd27: w = u_mul(SRC_R3, MB_KD);
            7'd28: w = u_rnd(SRC_R3);
            7'd29: w = u_alu(OP_NEG, SRC_R3, SRC_R3, SRC_ZERO);
            7'd30: w = u_wr(AD_DIAG, SRC_R2, SRC_R3);
            // Sub-diagonal entry.
            7'd31: w = u_mul(SRC_R0, MB_S);
            7'd32: w = u_rnd(SRC_R2);
            7'd33: w = u_mul(SRC_R2, MB_KS);
            7'd34: w = u_rnd(SRC_R2);
            7'd35: w = u_mul(SRC_R0, MB_C);
            7'd36: w = u_rnd(SRC_R3);
            7'd37: w = u_mul(SRC_R1, MB_S);
            7'd38: w = u_rnd(SRC_R4);
            7'd39: w = u_alu(OP_ADD, SRC_R3, SRC_R3, SRC_R4);
            7'd40: w = u_mul(SRC_R3, MB_KS);
            7'd41: w = u_rnd(SRC_R3);
            7'd42: begin
                w = u_wr(AD_SUB, SRC_R2, SRC_R3);
                w.j_op = CNT_CLR;
            end
            // Three-term recursion over the deeper orders.
            7'd43: begin
                w.cond = C_GEN_STOP;
                w.target = PC_EP;
            end
            7'd44: w = u_rd(AD_I1);
            7'd45: w = u_alu(OP_MOV, SRC_R0, SRC_MV, SRC_ZERO);
            7'd46: begin
                w = u_alu(OP_MOV, SRC_R1, SRC_MS, SRC_ZERO);
                w.rd = 1'b1;
                w.addr = AD_I2;
            end
            7'd47: w = u_alu(OP_MOV, SRC_R2, SRC_MV, SRC_ZERO);
            7'd48: w = u_alu(OP_MOV, SRC_R3, SRC_MS, SRC_ZERO);
            7'd49: w = u_mul(SRC_R0, MB_S);
            7'd50: w = u_rnd(SRC_R4);
            7'd51: w = u_mul(SRC_R4, MB_KB);
            7'd52: w = u_rnd(SRC_R4);
            7'd53: w = u_mul(SRC_R2, MB_KC);
            7'd54: w = u_rnd(SRC_R2);
            7'd55: w = u_alu(OP_SUB, SRC_R4, SRC_R4, SRC_R2);
            7'd56: w = u_mul(SRC_R4, MB_KA);
            7'd57: w = u_rnd(SRC_R4);
            7'd58: w = u_mul(SRC_R1, MB_S);
            7'd59: w = u_rnd(SRC_R1);
            7'd60: w = u_mul(SRC_R0, MB_C);
            7'd61: w = u_rnd(SRC_R0);
            7'd62: w = u_alu(OP_ADD, SRC_R1, SRC_R1, SRC_R0);
            7'd63: w = u_mul(SRC_R1, MB_KB);
            7'd64: w = u_rnd(SRC_R1);
            7'd65: w = u_mul(SRC_R3, MB_KC);
            7'd66: w = u_rnd(SRC_R3);
            7'd67: w = u_alu(OP_SUB, SRC_R1, SRC_R1, SRC_R3);
            7'd68: w = u_mul(SRC_R1, MB_KA);
            7'd69: w = u_rnd(SRC_R1);
            7'd70: begin
                w = u_wr(AD_CUR, SRC_R4, SRC_R1);
                w.j_op = CNT_INC;
                w.cond = C_ALWAYS;
                w.target = PC_G0;
            end
            7'd71: begin
                w.j_op = CNT_CLR;
                w.cond = C_ALWAYS;
                w.target = PC_E0;
            end
            7'd72: w.done = 1'b1;
            default: w.done = 1'b1;
        endcase
        return w;
    endfunction

    // Rotation angles in Q3.28.
    function automatic logic signed [31:0] atan_q28(input logic [CIT_W-1:0] i);
        logic signed [31:0] a;
        case (i)
            5'd0: a = 32'sd210828714;
            5'd1: a = 32'sd124459457;
            5'd2: a = 32'sd65760959;
            5'd3: a = 32'sd33381290;
            5'd4: a = 32'sd16755422;
            5'd5: a = 32'sd8385879;
            5'd6: a = 32'sd4193963;
            5'd7: a = 32'sd2097109;
            5'd8: a = 32'sd1048571;
            5'd9: a = 32'sd524287;
            default: a = 32'sd1 <<< (5'd28 - i);
        endcase
        return a;
    endfunction

    // floor(sqrt(num/den) * 2^28), found bit by bit; used at elaboration only.
    function automatic logic [31:0] coef_q28(input int unsigned num, input int unsigned den);
        logic [79:0] lhs;
        logic [79:0] rhs;
        logic [31:0] r;
        logic [31:0] cand;
        r = '0;
        rhs = 80'(num) << 56;
        if (den != 0) begin
            for (int b = 31; b >= 0; b--) begin
                cand = r | (32'd1 << b);
                lhs = 80'(cand) * 80'(cand) * 80'(den);
                if (lhs <= rhs) begin
                    r = cand;
                end
            end
        end
        return r;
    endfunction

    // Saturation to the signed 32-bit range.
    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v > 33'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -33'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/normalized_legendre_table.sv
// Top level of the normalised associated Legendre table for one latitude.
// Holds the rotation unit, the sequencer, the shared multiplier datapath and the stores.
// Depends on nlt_pkg for the program, the types and the fixed-point helpers.
`default_nettype none

// A latitude is taken when start is high and busy is low; busy then stays high until
// the last entry has gone out. Entries leave one at a time on result_valid, degree-major
// with orders ascending, and last marks the final one; the receiver cannot stall them.
// A latitude first runs the sine and cosine rotation, then the program runs every
// product through the one shared multiplier as a multiply step and a rounding step.
// Configuration writes are taken whenever valid is high and must only be made while
// busy is low.
module normalized_legendre_table #(
    parameter int MAX_DEGREE = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic signed [29:0]             latitude,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [nlt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [3:0]                     cfg_data,
    output logic                                result_valid,
    output logic [3:0]                          degree,
    output logic [3:0]                          order,
    output logic signed [31:0]                  p_value,
    output logic signed [31:0]                  dp_value,
    output logic                                last
);

    localparam int SIDE  = MAX_DEGREE + 1;
    localparam int DEPTH = SIDE * SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int DW    = $clog2(SIDE);

    // Coefficient tables, worked out at elaboration.
    logic [31:0] kd_tab [SIDE];
    logic [31:0] ks_tab [SIDE];
    logic [31:0] kb_tab [SIDE];
    logic [31:0] ka_tab [DEPTH];
    logic [31:0] kc_tab [DEPTH];

    for (genvar gd = 0; gd < SIDE; gd++) begin : g_deg
        if (gd == 1) begin : g_one
            assign kd_tab[gd] = nlt_pkg::coef_q28(3, 1);
        end else begin : g_other
            assign kd_tab[gd] = nlt_pkg::coef_q28(2 * gd + 1, 2 * gd);
        end
        assign ks_tab[gd] = nlt_pkg::coef_q28(2 * gd + 1, 1);
        if (gd > 0) begin : g_kb
            assign kb_tab[gd] = nlt_pkg::coef_q28(2 * gd - 1, 1);
        end else begin : g_kb0
            assign kb_tab[gd] = '0;
        end
        for (genvar gj = 0; gj < SIDE; gj++) begin : g_ord
            if (gj + 2 <= gd) begin : g_rec
                assign ka_tab[gd * SIDE + gj] =
                    nlt_pkg::coef_q28(2 * gd + 1, (gd - gj) * (gd + gj));
                assign kc_tab[gd * SIDE + gj] =
                    nlt_pkg::coef_q28((gd + gj - 1) * (gd - gj - 1), 2 * gd - 3);
            end else begin : g_none
                assign ka_tab[gd * SIDE + gj] = '0;
                assign kc_tab[gd * SIDE + gj] = '0;
            end
        end
    end

    // Control and configuration state.
    logic                              busy_reg, busy_next;
    logic [nlt_pkg::PC_W-1:0]          pc_reg, pc_next;
    logic [DW-1:0]                     d_reg, d_next;
    logic [DW-1:0]                     j_reg, j_next;
    logic [3:0]                        max_degree_reg;
    logic [3:0]                        max_order_reg;
    nlt_pkg::uword_t                   uw;
    logic                              accept;

    // Rotation unit state.
    logic                              cbusy_reg;
    logic                              cflip_reg;
    logic [nlt_pkg::CIT_W-1:0]         citer_reg;
    logic signed [33:0]                cx_reg, cy_reg;
    logic signed [31:0]                cz_reg;
    logic signed [31:0]                sine_reg, cosine_reg;

    // Datapath state.
    logic signed [31:0]                r0_reg, r1_reg, r2_reg, r3_reg, r4_reg, r5_reg;
    logic signed [63:0]                prod_reg;
    logic                              prod_trig_reg;
    logic signed [31:0]                mem_v_reg, mem_s_reg;
    logic [31:0]                       value_mem [DEPTH];
    logic [31:0]                       slope_mem [DEPTH];

    // Result registers.
    logic                              result_valid_reg;
    logic [3:0]                        degree_reg, order_reg;
    logic signed [31:0]                p_value_reg, dp_value_reg;
    logic                              last_reg;

    assign accept    = start && !busy_reg;
    assign cfg_ready = 1'b1;
    assign uw        = nlt_pkg::ucode(pc_reg);

    // Effective limits from the configuration registers.
    logic [3:0] n_eff, mo_eff;
    always_comb
    begin
        if (max_degree_reg == 4'd0) begin
            n_eff = 4'd1;
        end else if (max_degree_reg > 4'(MAX_DEGREE)) begin
            n_eff = 4'(MAX_DEGREE);
        end else begin
            n_eff = max_degree_reg;
        end
        if (max_order_reg > 4'(MAX_DEGREE)) begin
            mo_eff = 4'(MAX_DEGREE);
        end else begin
            mo_eff = max_order_reg;
        end
    end

    // Loop conditions of the program.
    logic d_is_one, j_lt_d, d_eq_n, gen_ok, emit_ok, is_last;
    always_comb
    begin
        d_is_one = (d_reg == DW'(1));
        j_lt_d   = (j_reg < d_reg);
        d_eq_n   = (4'(d_reg) == n_eff);
        gen_ok   = (({2'b00, j_reg} + (DW + 2)'(2)) <= {2'b00, d_reg})
                   && (4'(j_reg) <= mo_eff);
        emit_ok  = (({1'b0, j_reg} + (DW + 1)'(1)) >= {1'b0, d_reg})
                   || (4'(j_reg) <= mo_eff);
        is_last  = d_eq_n && (j_reg == d_reg);
    end

    // Store address for the current step.
    logic [AW-1:0] addr, cur_addr;
    always_comb
    begin
        cur_addr = AW'(int'(d_reg) * SIDE + int'(j_reg));
        case (uw.addr)
            nlt_pkg::AD_CUR:  addr = cur_addr;
            nlt_pkg::AD_DIAG: addr = AW'(int'(d_reg) * SIDE + int'(d_reg));
            nlt_pkg::AD_SUB:  addr = AW'(int'(d_reg) * SIDE + int'(d_reg) - 1);
            nlt_pkg::AD_PD:   addr = AW'((int'(d_reg) - 1) * (SIDE + 1));
            nlt_pkg::AD_I1:   addr = AW'((int'(d_reg) - 1) * SIDE + int'(j_reg));
            nlt_pkg::AD_I2:   addr = AW'((int'(d_reg) - 2) * SIDE + int'(j_reg));
            default:          addr = cur_addr;
        endcase
    end

    // Sequencer: step counter, jumps and loop counters.
    logic take;
    always_comb
    begin
        case (uw.cond)
            nlt_pkg::C_NEXT:        take = 1'b0;
            nlt_pkg::C_ALWAYS:      take = 1'b1;
            nlt_pkg::C_CORDIC_BUSY: take = cbusy_reg;
            nlt_pkg::C_D_IS_ONE:    take = d_is_one;
            nlt_pkg::C_J_LT_D:      take = j_lt_d;
            nlt_pkg::C_D_EQ_N:      take = d_eq_n;
            nlt_pkg::C_GEN_STOP:    take = !gen_ok;
            default:                take = 1'b0;
        endcase
        busy_next = busy_reg;
        pc_next   = pc_reg;
        d_next    = d_reg;
        j_next    = j_reg;
        if (accept) begin
            busy_next = 1'b1;
            pc_next   = nlt_pkg::PC_WAITC;
        end else if (busy_reg) begin
            if (uw.done) begin
                busy_next = 1'b0;
            end else if (take) begin
                pc_next = uw.target;
            end else begin
                pc_next = pc_reg + nlt_pkg::PC_W'(1);
            end
            case (uw.d_op)
                nlt_pkg::CNT_CLR: d_next = '0;
                nlt_pkg::CNT_INC: d_next = d_reg + DW'(1);
                default:          d_next = d_reg;
            endcase
            case (uw.j_op)
                nlt_pkg::CNT_CLR: j_next = '0;
                nlt_pkg::CNT_INC: j_next = j_reg + DW'(1);
                default:          j_next = j_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            pc_reg   <= nlt_pkg::PC_DONE;
            d_reg    <= '0;
            j_reg    <= '0;
        end else begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
            d_reg    <= d_next;
            j_reg    <= j_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_degree_reg <= 4'd8;
            max_order_reg  <= 4'd8;
        end else if (cfg_valid) begin
            if (cfg_index == nlt_pkg::CFG_MAX_DEGREE) begin
                max_degree_reg <= cfg_data;
            end else if (cfg_index == nlt_pkg::CFG_MAX_ORDER) begin
                max_order_reg <= cfg_data;
            end
        end
    end

    // Rotation unit: one shift-and-add step per cycle.
    logic signed [31:0] z0, zf, ang;
    logic               flip0;
    logic signed [33:0] sh_x, sh_y, nx, ny, cx_cl, cy_cl;
    always_comb
    begin
        z0 = {{2{latitude[29]}}, latitude};
        if (z0 > nlt_pkg::HALF_PI_Q28) begin
            zf    = nlt_pkg::PI_Q28 - z0;
            flip0 = 1'b1;
        end else if (z0 < -nlt_pkg::HALF_PI_Q28) begin
            zf    = -nlt_pkg::PI_Q28 - z0;
            flip0 = 1'b1;
        end else begin
            zf    = z0;
            flip0 = 1'b0;
        end
        ang  = nlt_pkg::atan_q28(citer_reg);
        sh_x = cx_reg >>> citer_reg;
        sh_y = cy_reg >>> citer_reg;
        if (!cz_reg[31]) begin
            nx = cx_reg - sh_y;
            ny = cy_reg + sh_x;
        end else begin
            nx = cx_reg + sh_y;
            ny = cy_reg - sh_x;
        end
        if (nx > nlt_pkg::TRIG_ONE) begin
            cx_cl = nlt_pkg::TRIG_ONE;
        end else if (nx < -nlt_pkg::TRIG_ONE) begin
            cx_cl = -nlt_pkg::TRIG_ONE;
        end else begin
            cx_cl = nx;
        end
        if (ny > nlt_pkg::TRIG_ONE) begin
            cy_cl = nlt_pkg::TRIG_ONE;
        end else if (ny < -nlt_pkg::TRIG_ONE) begin
            cy_cl = -nlt_pkg::TRIG_ONE;
        end else begin
            cy_cl = ny;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cbusy_reg  <= 1'b0;
            cflip_reg  <= 1'b0;
            citer_reg  <= '0;
            sine_reg   <= '0;
            cosine_reg <= '0;
        end else if (accept) begin
            cbusy_reg <= 1'b1;
            cflip_reg <= flip0;
            citer_reg <= '0;
        end else if (cbusy_reg) begin
            citer_reg <= citer_reg + nlt_pkg::CIT_W'(1);
            if (citer_reg == nlt_pkg::CIT_W'(nlt_pkg::CORDIC_STEPS - 1)) begin
                cbusy_reg <= 1'b0;
                sine_reg  <= cy_cl[31:0];
                if (cflip_reg) begin
                    cosine_reg <= -cx_cl[31:0];
                end else begin
                    cosine_reg <= cx_cl[31:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            cx_reg <= nlt_pkg::GAIN_Q30;
            cy_reg <= '0;
            cz_reg <= zf;
        end else if (cbusy_reg) begin
            cx_reg <= nx;
            cy_reg <= ny;
            if (!cz_reg[31]) begin
                cz_reg <= cz_reg - ang;
            end else begin
                cz_reg <= cz_reg + ang;
            end
        end
    end

    // Operand selection.
    function automatic logic signed [31:0] pick(input nlt_pkg::src_t s,
        input logic signed [31:0] a0, input logic signed [31:0] a1,
        input logic signed [31:0] a2, input logic signed [31:0] a3,
        input logic signed [31:0] a4, input logic signed [31:0] a5,
        input logic signed [31:0] mv, input logic signed [31:0] ms);
        logic signed [31:0] v;
        case (s)
            nlt_pkg::SRC_R0:   v = a0;
            nlt_pkg::SRC_R1:   v = a1;
            nlt_pkg::SRC_R2:   v = a2;
            nlt_pkg::SRC_R3:   v = a3;
            nlt_pkg::SRC_R4:   v = a4;
            nlt_pkg::SRC_R5:   v = a5;
            nlt_pkg::SRC_MV:   v = mv;
            nlt_pkg::SRC_MS:   v = ms;
            nlt_pkg::SRC_ONE:  v = nlt_pkg::ONE_Q24;
            default:           v = '0;
        endcase
        return v;
    endfunction

    logic signed [31:0] a_val, b_val, mb_val, res_val, rnd_val;
    logic signed [63:0] rnd_sum, rnd_sh;
    logic               res_we;
    always_comb
    begin
        a_val = pick(uw.src_a, r0_reg, r1_reg, r2_reg, r3_reg, r4_reg, r5_reg,
                     mem_v_reg, mem_s_reg);
        b_val = pick(uw.src_b, r0_reg, r1_reg, r2_reg, r3_reg, r4_reg, r5_reg,
                     mem_v_reg, mem_s_reg);
        case (uw.mb)
            nlt_pkg::MB_S:  mb_val = sine_reg;
            nlt_pkg::MB_C:  mb_val = cosine_reg;
            nlt_pkg::MB_KD: mb_val = kd_tab[d_reg];
            nlt_pkg::MB_KS: mb_val = ks_tab[d_reg];
            nlt_pkg::MB_KB: mb_val = kb_tab[d_reg];
            nlt_pkg::MB_KA: mb_val = ka_tab[cur_addr];
            nlt_pkg::MB_KC: mb_val = kc_tab[cur_addr];
            default:        mb_val = '0;
        endcase
        // Round and scale the held product.
        if (prod_trig_reg) begin
            rnd_sum = prod_reg + (64'sd1 <<< 29);
            rnd_sh  = rnd_sum >>> 30;
        end else begin
            rnd_sum = prod_reg + (64'sd1 <<< 27);
            rnd_sh  = rnd_sum >>> 28;
        end
        rnd_val = nlt_pkg::sat64(rnd_sh);
        res_we  = busy_reg;
        case (uw.op)
            nlt_pkg::OP_MOV: res_val = a_val;
            nlt_pkg::OP_ADD: res_val = nlt_pkg::sat33({a_val[31], a_val} + {b_val[31], b_val});
            nlt_pkg::OP_SUB: res_val = nlt_pkg::sat33({a_val[31], a_val} - {b_val[31], b_val});
            nlt_pkg::OP_NEG: res_val = nlt_pkg::sat33(33'sd0 - {a_val[31], a_val});
            nlt_pkg::OP_RND: res_val = rnd_val;
            default:
            begin
                res_val = '0;
                res_we  = 1'b0;
            end
        endcase
    end

    // Working registers and the multiplier.
    always_ff @(posedge clk)
    begin
        if (res_we) begin
            case (uw.dst)
                nlt_pkg::SRC_R0: r0_reg <= res_val;
                nlt_pkg::SRC_R1: r1_reg <= res_val;
                nlt_pkg::SRC_R2: r2_reg <= res_val;
                nlt_pkg::SRC_R3: r3_reg <= res_val;
                nlt_pkg::SRC_R4: r4_reg <= res_val;
                default:         r5_reg <= res_val;
            endcase
        end
        if (busy_reg && uw.op == nlt_pkg::OP_MUL) begin
            prod_reg      <= a_val * mb_val;
            prod_trig_reg <= (uw.mb == nlt_pkg::MB_S) || (uw.mb == nlt_pkg::MB_C);
        end
    end

    // Value and slope stores with registered reads.
    always_ff @(posedge clk)
    begin
        if (busy_reg && uw.wr) begin
            value_mem[addr] <= a_val;
            slope_mem[addr] <= b_val;
        end
        if (busy_reg && uw.rd) begin
            mem_v_reg <= value_mem[addr];
            mem_s_reg <= slope_mem[addr];
        end
    end

    // Result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            result_valid_reg <= 1'b0;
        end else begin
            result_valid_reg <= busy_reg && uw.emit && emit_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && uw.emit) begin
            degree_reg   <= 4'(d_reg);
            order_reg    <= 4'(j_reg);
            p_value_reg  <= mem_v_reg;
            dp_value_reg <= mem_s_reg;
            last_reg     <= is_last;
        end
    end

    assign busy         = busy_reg;
    assign result_valid = result_valid_reg;
    assign degree       = degree_reg;
    assign order        = order_reg;
    assign p_value      = p_value_reg;
    assign dp_value     = dp_value_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

>>> rtl/nlt_checker.sv
// Port-level checks for the normalised Legendre table, bound to the top level.
// Watches the command and result ports only; depends on nothing else.
`default_nettype none

module nlt_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       result_valid,
    input wire logic [3:0] degree,
    input wire logic [3:0] order,
    input wire logic       last
);

    // A taken latitude makes the block busy.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("latitude taken but block not busy");

    // Entries appear only while a latitude is being worked on.
    a_result_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("entry emitted while idle");

    // The order of an entry never exceeds its degree.
    a_order_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> order <= degree)
        else $error("entry order above its degree");

    // Nothing follows the marked final entry.
    a_last_final: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |=> !result_valid)
        else $error("entry after the final one");

    // The block only goes idle after the final entry.
    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(result_valid && last, 2))
        else $error("block went idle without a final entry");

endmodule

bind normalized_legendre_table nlt_checker u_nlt_checker (.*);

`default_nettype wire
